// ===== design/aes256_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-256 package
// S-box tables, GF(2^8) helpers and the sequencer state type.
// ----------------------------------------------------------------------------
package aes256_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEYFWD,
        ST_ROUND,
        ST_DONE
    } aes_state_t;

    localparam int NumRounds = 14;

    localparam logic [4:0] CFG_KEY0 = 5'd0;
    localparam logic [4:0] CFG_KEY1 = 5'd1;
    localparam logic [4:0] CFG_KEY2 = 5'd2;
    localparam logic [4:0] CFG_KEY3 = 5'd3;
    localparam logic [4:0] CFG_DIR  = 5'd4;

    function automatic logic [7:0] xt(input logic [7:0] x);
        xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = t[x];
    endfunction

    function automatic logic [7:0] sbox_rev(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        sbox_rev = t[x];
    endfunction

endpackage

// ===== design/aes256_keysched.sv =====
// ----------------------------------------------------------------------------
// AES-256 key schedule unit
// Steps a sliding window of eight key words forwards or backwards, four words
// per step, and presents the current round key.
// ----------------------------------------------------------------------------
module aes256_keysched
    import aes256_pkg::*;
(
    input  logic         aclk,
    input  logic         load,
    input  logic [255:0] key,
    input  logic         fwd,
    input  logic         bwd,
    output logic [127:0] rkey_lo,
    output logic [127:0] rkey_hi
);

    logic [255:0] win_reg, win_next;
    logic [7:0]   rc_reg, rc_next;
    logic         phase_reg, phase_next;
    logic [31:0]  w [8];
    logic [31:0]  n [8];
    logic [31:0]  t;

    function automatic logic [31:0] subw(input logic [31:0] x);
        subw = {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
    endfunction

    function automatic logic [7:0] xt_inv(input logic [7:0] x);
        xt_inv = x[0] ? ({1'b1, x[7:1]} ^ 8'h0D) : {1'b0, x[7:1]};
    endfunction

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w[i] = win_reg[255 - 32 * i -: 32];
            n[i] = w[i];
        end
        t = '0;
        rc_next = rc_reg;
        win_next = win_reg;
        if (load) begin
            win_next = key;
            rc_next  = 8'h01;
        end else if (fwd) begin
            // The window is either even-aligned (rcon step next) or odd.
            n[0] = w[4];
            n[1] = w[5];
            n[2] = w[6];
            n[3] = w[7];
            if (phase_reg == 1'b0) begin
                n[4] = w[0] ^ subw({w[7][23:0], w[7][31:24]}) ^ {rc_reg, 24'h0};
                rc_next = xt(rc_reg);
            end else begin
                n[4] = w[0] ^ subw(w[7]);
            end
            n[5] = w[1] ^ n[4];
            n[6] = w[2] ^ n[5];
            n[7] = w[3] ^ n[6];
            for (int i = 0; i < 8; i++) begin
                win_next[255 - 32 * i -: 32] = n[i];
            end
        end else if (bwd) begin
            n[4] = w[0];
            n[5] = w[1];
            n[6] = w[2];
            n[7] = w[3];
            n[3] = w[7] ^ w[6];
            n[2] = w[6] ^ w[5];
            n[1] = w[5] ^ w[4];
            if (phase_reg == 1'b1) begin
                t = {w[3][23:0], w[3][31:24]};
                n[0] = w[4] ^ subw(t) ^ {xt_inv(rc_reg), 24'h0};
                rc_next = xt_inv(rc_reg);
            end else begin
                n[0] = w[4] ^ subw(w[3]);
            end
            for (int i = 0; i < 8; i++) begin
                win_next[255 - 32 * i -: 32] = n[i];
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        if (load) begin
            phase_next = 1'b0;
        end else if (fwd || bwd) begin
            phase_next = ~phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg   <= win_next;
        rc_reg    <= rc_next;
        phase_reg <= phase_next;
    end

    assign rkey_lo = win_reg[255:128];
    assign rkey_hi = win_reg[127:0];

endmodule

// ===== design/aes256_round.sv =====
// ----------------------------------------------------------------------------
// AES-256 round unit
// One forward or inverse cipher round on the 128-bit state.
// ----------------------------------------------------------------------------
module aes256_round
    import aes256_pkg::*;
(
    input  logic [127:0] state_in,
    input  logic [127:0] rkey,
    input  logic         decrypt,
    input  logic         last,
    output logic [127:0] state_out
);

    logic [7:0] s [16];
    logic [7:0] a [16];
    logic [7:0] m [16];
    logic [7:0] x2, x4, x8;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = state_in[127 - 8 * i -: 8];
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (decrypt) begin
                    a[r + 4 * ((c + r) % 4)] = sbox_rev(s[r + 4 * c]);
                end else begin
                    a[r + 4 * c] = sbox(s[r + 4 * ((c + r) % 4)]);
                end
            end
        end
        for (int i = 0; i < 16; i++) begin
            if (decrypt) begin
                a[i] = a[i] ^ rkey[127 - 8 * i -: 8];
            end
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                m[4 * c + r] = '0;
                for (int k = 0; k < 4; k++) begin
                    x2 = xt(a[4 * c + k]);
                    x4 = xt(x2);
                    x8 = xt(x4);
                    if (decrypt) begin
                        case ((k - r) & 3)
                            0: m[4 * c + r] ^= x8 ^ x4 ^ x2;
                            1: m[4 * c + r] ^= x8 ^ x2 ^ a[4 * c + k];
                            2: m[4 * c + r] ^= x8 ^ x4 ^ a[4 * c + k];
                            default: m[4 * c + r] ^= x8 ^ a[4 * c + k];
                        endcase
                    end else begin
                        case ((k - r) & 3)
                            0: m[4 * c + r] ^= x2;
                            1: m[4 * c + r] ^= x2 ^ a[4 * c + k];
                            default: m[4 * c + r] ^= a[4 * c + k];
                        endcase
                    end
                end
            end
        end
        for (int i = 0; i < 16; i++) begin
            if (last) begin
                state_out[127 - 8 * i -: 8] = decrypt ? a[i] : a[i] ^ rkey[127 - 8 * i -: 8];
            end else begin
                state_out[127 - 8 * i -: 8] = decrypt ? m[i] : m[i] ^ rkey[127 - 8 * i -: 8];
            end
        end
    end

endmodule

// ===== design/aes256_block_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// AES-256 block cipher unit
// ECB encryption or decryption of 128-bit blocks with a 256-bit key.
// ----------------------------------------------------------------------------
// One block is taken, then s_ready stays low while a single shared round unit
// runs the fourteen rounds, one per cycle, after the initial key addition.
// Decryption first rolls the key schedule forward to reach the last round
// key. The result moves into an output register and is held on the m_ side
// until taken; the next beat can be accepted from the cycle after the result
// has moved there, while the result still waits.
module aes256_block_cipher_unit
    import aes256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_block_high,
    input  logic [63:0] s_block_low,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_high,
    output logic [63:0] m_result_low,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    aes_state_t   state_reg, state_next;
    logic [255:0] key_reg;
    logic         dir_reg, dir_op_reg, dir_op_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] out_reg, out_next;
    logic         out_valid_reg, out_valid_next;
    logic [127:0] rkey_lo, rkey_hi, rnd_out;
    logic         ks_load, ks_fwd, ks_bwd, last;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
            dir_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_KEY0: key_reg[255:192] <= cfg_data;
                CFG_KEY1: key_reg[191:128] <= cfg_data;
                CFG_KEY2: key_reg[127:64]  <= cfg_data;
                CFG_KEY3: key_reg[63:0]    <= cfg_data;
                CFG_DIR:  dir_reg          <= cfg_data[0];
                default: ;
            endcase
        end
    end

    aes256_keysched u_ks (
        .aclk    (aclk),
        .load    (ks_load),
        .key     (key_reg),
        .fwd     (ks_fwd),
        .bwd     (ks_bwd),
        .rkey_lo (rkey_lo),
        .rkey_hi (rkey_hi)
    );

    assign last = dir_op_reg ? (cnt_reg == 4'd0) : (cnt_reg == 4'(NumRounds));

    aes256_round u_round (
        .state_in  (st_reg),
        .rkey      (rkey_lo),
        .decrypt   (dir_op_reg),
        .last      (last),
        .state_out (rnd_out)
    );

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        st_next        = st_reg;
        dir_op_next    = dir_op_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ks_load        = 1'b0;
        ks_fwd         = 1'b0;
        ks_bwd         = 1'b0;
        s_ready        = (state_reg == ST_IDLE);
        m_valid        = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ks_load     = 1'b1;
                    dir_op_next = dir_reg;
                    st_next     = {s_block_high, s_block_low};
                    cnt_next    = '0;
                    state_next  = dir_reg ? ST_KEYFWD : ST_ROUND;
                end
            end
            ST_KEYFWD: begin
                // Window ends holding words 52..59 with round key 14 in rkey_hi, the lower bits.
                ks_fwd   = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd12) begin
                    cnt_next   = 4'(NumRounds);
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (!dir_op_reg) begin
                    if (cnt_reg == '0) begin
                        st_next = st_reg ^ rkey_lo;
                    end else begin
                        st_next = rnd_out;
                    end
                    ks_fwd   = 1'b1;
                    cnt_next = cnt_reg + 4'd1;
                end else begin
                    if (cnt_reg == 4'(NumRounds)) begin
                        st_next = st_reg ^ rkey_hi;
                    end else begin
                        st_next = rnd_out;
                        ks_bwd  = 1'b1;
                    end
                    cnt_next = cnt_reg - 4'd1;
                end
                if (last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_next       = st_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        cnt_reg    <= cnt_next;
        st_reg     <= st_next;
        dir_op_reg <= dir_op_next;
        out_reg    <= out_next;
    end

    assign m_result_high = out_reg[127:64];
    assign m_result_low  = out_reg[63:0];

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// AES-256 block cipher unit testbench
// Drives blocks through the cipher under a range of keys and both directions,
// predicts every result with an independent behavioural cipher, and checks
// each result beat in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import aes256_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 2000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_block_high;
    logic [63:0] s_block_low;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_result_high;
    logic [63:0] m_result_low;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_index;
    logic [63:0] cfg_data;

    logic [63:0]  key_q [4];
    logic         dir_q;
    logic [7:0]   fwd_tab [256];
    logic [7:0]   inv_tab [256];
    logic [127:0] expected_blocks [$];
    int           error_count;
    int           idle_cycles;
    bit           no_idle;

    aes256_block_cipher_unit u_top (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = gf_double(a);
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_inverse(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h01;
        p = x;
        for (int e = 0; e < 8; e++) begin
            if (e != 0) r = gf_mul(r, p);
            p = gf_mul(p, p);
        end
        return r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
    endfunction

    function automatic logic [127:0] sub_state(input logic [127:0] st, input logic inv);
        for (int i = 0; i < 16; i++) begin
            st[127-8*i -: 8] = inv ? inv_tab[st[127-8*i -: 8]] : fwd_tab[st[127-8*i -: 8]];
        end
        return st;
    endfunction

    function automatic logic [127:0] shift_state(input logic [127:0] st, input logic inv);
        logic [127:0] t;
        int src;
        t = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                src = r + 4 * ((c + r) & 3);
                if (inv) t[127-8*src -: 8] = st[127-8*(r+4*c) -: 8];
                else t[127-8*(r+4*c) -: 8] = st[127-8*src -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_state(input logic [127:0] st, input logic inv);
        logic [7:0] a [4];
        logic [7:0] m [4];
        logic [7:0] v;
        if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
        else m = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = st[127-8*(4*c+r) -: 8];
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int k = 0; k < 4; k++) v ^= gf_mul(a[k], m[(k - r) & 3]);
                st[127-8*(4*c+r) -: 8] = v;
            end
        end
        return st;
    endfunction

    function automatic logic [127:0] cipher_block(input logic [127:0] blk);
        logic [31:0]  w [60];
        logic [255:0] key_all;
        logic [31:0]  tw;
        logic [7:0]   rc;
        logic [127:0] st;
        key_all = {key_q[0], key_q[1], key_q[2], key_q[3]};
        for (int i = 0; i < 8; i++) w[i] = key_all[255-32*i -: 32];
        rc = 8'h01;
        for (int i = 8; i < 60; i++) begin
            tw = w[i-1];
            if (i % 8 == 0) begin
                tw = sub_word({tw[23:0], tw[31:24]}) ^ {rc, 24'h0};
                rc = gf_double(rc);
            end else if (i % 8 == 4) begin
                tw = sub_word(tw);
            end
            w[i] = w[i-8] ^ tw;
        end
        st = blk;
        if (!dir_q) begin
            st ^= {w[0], w[1], w[2], w[3]};
            for (int rnd = 1; rnd <= NumRounds; rnd++) begin
                st = shift_state(sub_state(st, 1'b0), 1'b0);
                if (rnd != NumRounds) st = mix_state(st, 1'b0);
                st ^= {w[4*rnd], w[4*rnd+1], w[4*rnd+2], w[4*rnd+3]};
            end
        end else begin
            st ^= {w[56], w[57], w[58], w[59]};
            for (int rnd = NumRounds - 1; rnd >= 0; rnd--) begin
                st = sub_state(shift_state(st, 1'b1), 1'b1);
                st ^= {w[4*rnd], w[4*rnd+1], w[4*rnd+2], w[4*rnd+3]};
                if (rnd != 0) st = mix_state(st, 1'b1);
            end
        end
        return st;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        int  gap;
        bit  hit;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_block_high <= hi;
        s_block_low  <= lo;
        do begin
            @(negedge aclk);
            hit = s_valid && s_ready;
            @(posedge aclk);
        end while (!hit);
        expected_blocks.push_back(cipher_block({hi, lo}));
    endtask

    task automatic write_reg(input logic [4:0] idx, input logic [63:0] data);
        bit hit;
        s_valid   <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(negedge aclk);
            hit = cfg_valid && cfg_ready;
            @(posedge aclk);
        end while (!hit);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_KEY0: key_q[0] = data;
            CFG_KEY1: key_q[1] = data;
            CFG_KEY2: key_q[2] = data;
            CFG_KEY3: key_q[3] = data;
            CFG_DIR:  dir_q = data[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic load_key(input logic [255:0] k, input logic [63:0] dir_word);
        write_reg(CFG_KEY0, k[255:192]);
        write_reg(CFG_KEY1, k[191:128]);
        write_reg(CFG_KEY2, k[127:64]);
        write_reg(CFG_KEY3, k[63:0]);
        write_reg(CFG_DIR, dir_word);
    endtask

    task automatic test_reset_key();
        send_block(64'h0, 64'h0);
        send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        drain();
    endtask

    task automatic test_standard_vector();
        load_key(256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f,
                 64'h0);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        drain();
        write_reg(CFG_DIR, 64'h1);
        send_block(64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        drain();
    endtask

    task automatic test_field_extremes();
        for (int d = 0; d < 2; d++) begin
            load_key('1, d ? 64'hFFFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF_FFFF_FFFE);
            send_block(64'h0, 64'h0);
            send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
            send_block(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
            send_block(64'h8000_0000_0000_0001, 64'h0123_4567_89AB_CDEF);
            drain();
        end
    endtask

    task automatic test_ignored_index();
        load_key(256'h0, 64'h0);
        for (int idx = 5; idx < 32; idx++) write_reg(idx[4:0], rand64());
        send_block(64'h0, 64'h0);
        send_block(rand64(), rand64());
        drain();
    endtask

    task automatic test_random_blocks();
        for (int ph = 0; ph < 8; ph++) begin
            no_idle = (ph % 4 == 3);
            load_key({rand64(), rand64(), rand64(), rand64()}, rand64());
            for (int n = 0; n < 200; n++) send_block(rand64(), rand64());
            drain();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        logic [127:0] want;
        bit           hit;
        logic [63:0]  got_hi;
        logic [63:0]  got_lo;
        int           gap;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(negedge aclk);
                hit    = m_valid && m_ready;
                got_hi = m_result_high;
                got_lo = m_result_low;
                @(posedge aclk);
            end while (!hit);
            if (expected_blocks.size() == 0) begin
                $error("result beat with nothing expected: %h %h", got_hi, got_lo);
                error_count++;
            end else begin
                want = expected_blocks.pop_front();
                if (got_hi !== want[127:64]) begin
                    $error("result_high expected %h actual %h", want[127:64], got_hi);
                    error_count++;
                end
                if (got_lo !== want[63:0]) begin
                    $error("result_low expected %h actual %h", want[63:0], got_lo);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
                || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_block_high = '0;
        s_block_low  = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        error_count  = 0;
        no_idle      = 1'b0;
        for (int i = 0; i < 4; i++) key_q[i] = '0;
        dir_q = 1'b0;
        for (int x = 0; x < 256; x++) begin
            logic [7:0] q;
            q = gf_inverse(x[7:0]);
            fwd_tab[x] = q ^ rotl8(q, 1) ^ rotl8(q, 2) ^ rotl8(q, 3) ^ rotl8(q, 4) ^ 8'h63;
        end
        for (int x = 0; x < 256; x++) inv_tab[fwd_tab[x]] = x[7:0];
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_key();
        test_standard_vector();
        test_field_extremes();
        test_ignored_index();
        test_random_blocks();

        if (expected_blocks.size() != 0) begin
            $error("%0d expected results never arrived", expected_blocks.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
